FILE: src/hav_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hav_pkg
// Shared constants, tables and helpers for the great-circle distance unit.
// ----------------------------------------------------------------------------
package hav_pkg;

  localparam int ANGLE_FRACTION_BITS_DEFAULT = 20;
  localparam int CORDIC_STAGES_DEFAULT       = 24;

  localparam int RADIUS_W = 29;
  localparam int DIST_W   = 31;
  localparam int LAT_W    = 28;
  localparam int LON_W    = 29;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 29'd259443917;
  localparam logic [DIST_W-1:0]   DIST_MAX     = 31'd1647099331;
  localparam logic [31:0]         TURN_MUL     = 32'd3054198966;
  localparam logic signed [33:0]  GAIN_Q30     = 34'sd652032874;
  localparam logic [30:0]         ONE_Q30      = 31'd1073741824;
  localparam logic [27:0]         FOUR_PI_Q24  = 28'd210828714;

  // Arctangent of 2^-k in units of 2^-32 turn.
  function automatic logic [29:0] atan_turn(input int k);
    logic [29:0] t;
    case (k)
      0: t = 30'd536870912;   1: t = 30'd316933406;   2: t = 30'd167458907;
      3: t = 30'd85004756;    4: t = 30'd42667331;    5: t = 30'd21354465;
      6: t = 30'd10679838;    7: t = 30'd5340245;     8: t = 30'd2670163;
      9: t = 30'd1335087;     10: t = 30'd667544;     11: t = 30'd333772;
      12: t = 30'd166886;     13: t = 30'd83443;      14: t = 30'd41721;
      15: t = 30'd20860;      16: t = 30'd10430;      17: t = 30'd5215;
      18: t = 30'd2607;       19: t = 30'd1303;       20: t = 30'd651;
      21: t = 30'd325;        22: t = 30'd162;        23: t = 30'd81;
      24: t = 30'd40;         25: t = 30'd20;         26: t = 30'd10;
      27: t = 30'd5;          28: t = 30'd2;          29: t = 30'd1;
      default: t = 30'd0;
    endcase
    return t;
  endfunction

endpackage

FILE: src/hav_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hav_core
// Stalling pipeline: angle scaling, four sin/cos CORDICs, products, two
// square roots, atan2 CORDIC and the radius multiply.
// ----------------------------------------------------------------------------
module hav_core #(
  parameter int ANGLE_FRACTION_BITS = hav_pkg::ANGLE_FRACTION_BITS_DEFAULT,
  parameter int CORDIC_STAGES       = hav_pkg::CORDIC_STAGES_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  logic                                in_valid,
  input  logic signed [hav_pkg::LAT_W-1:0]    lat1,
  input  logic signed [hav_pkg::LON_W-1:0]    lon1,
  input  logic signed [hav_pkg::LAT_W-1:0]    lat2,
  input  logic signed [hav_pkg::LON_W-1:0]    lon2,
  input  logic        [hav_pkg::RADIUS_W-1:0] radius,
  output logic                                out_valid,
  output logic        [hav_pkg::DIST_W-1:0]   distance
);
  import hav_pkg::*;

  localparam int N  = CORDIC_STAGES;
  localparam int SQ = 31;          // root bits, one per stage
  // stage map
  localparam int S_ANG = 1;
  localparam int S_CS  = S_ANG + N;        // sincos done
  localparam int S_P1  = S_CS + 1;         // c1c2, sdl^2, sdo^2
  localparam int S_P2  = S_P1 + 1;         // cc*sdo2
  localparam int S_A   = S_P2 + 1;         // clamped a
  localparam int S_SQ  = S_A + SQ;         // roots
  localparam int S_AT  = S_SQ + N;         // atan2
  localparam int S_W   = S_AT + 1;         // w
  localparam int S_M   = S_W + 1;          // R*wh, R*wl
  localparam int S_O   = S_M + 1;          // distance
  localparam int DEPTH = S_O;

  logic [DEPTH:1] vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEPTH-1:1], in_valid};
    end
  end
  assign out_valid = vld[DEPTH];

  // radius is read live, not checked; the user keeps it stable while busy
  // ---------------- angle conversion ----------------
  logic [31:0] th [4];
  function automatic logic [31:0] turns(input logic signed [29:0] d, input int ex);
    logic signed [63:0] p;
    p = 64'(d) * $signed({1'b0, TURN_MUL});
    return 32'(p >>> (ANGLE_FRACTION_BITS + 8 + ex));
  endfunction
  always_ff @(posedge clk) begin
    if (adv) begin
      th[0] <= turns(30'(lat1), 0);
      th[1] <= turns(30'(lat2), 0);
      th[2] <= turns(30'(lat2) - 30'(lat1), 1);
      th[3] <= turns(30'(lon2) - 30'(lon1), 1);
    end
  end

  // ---------------- sin/cos CORDIC, 4 lanes ----------------
  logic signed [33:0] cx [4][N+1];
  logic signed [33:0] cy [4][N+1];
  logic signed [31:0] cz [4][N+1];
  logic        [1:0]  cq [4][N+1];
  for (genvar l = 0; l < 4; l++) begin : g_lane
    always_comb begin
      cx[l][0] = GAIN_Q30;
      cy[l][0] = '0;
      cz[l][0] = 32'({2'b00, th[l][29:0]});
      cq[l][0] = th[l][31:30];
    end
    for (genvar i = 0; i < N; i++) begin : g_st
      always_ff @(posedge clk) begin
        if (adv) begin
          cq[l][i+1] <= cq[l][i];
          if (!cz[l][i][31]) begin
            cx[l][i+1] <= cx[l][i] - (cy[l][i] >>> (i % 32));
            cy[l][i+1] <= cy[l][i] + (cx[l][i] >>> (i % 32));
            cz[l][i+1] <= cz[l][i] - 32'(atan_turn(i % 32));
          end else begin
            cx[l][i+1] <= cx[l][i] + (cy[l][i] >>> (i % 32));
            cy[l][i+1] <= cy[l][i] - (cx[l][i] >>> (i % 32));
            cz[l][i+1] <= cz[l][i] + 32'(atan_turn(i % 32));
          end
        end
      end
    end
  end

  logic signed [33:0] cosv [4];
  logic signed [33:0] sinv [4];
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      case (cq[l][N])
        2'd0: begin cosv[l] = cx[l][N];  sinv[l] = cy[l][N];  end
        2'd1: begin cosv[l] = -cy[l][N]; sinv[l] = cx[l][N];  end
        2'd2: begin cosv[l] = -cx[l][N]; sinv[l] = -cy[l][N]; end
        default: begin cosv[l] = cy[l][N]; sinv[l] = -cx[l][N]; end
      endcase
    end
  end

  // ---------------- products ----------------
  logic signed [33:0] cc, sdl2, sdo2, t2, sdl2_d;
  always_ff @(posedge clk) begin
    if (adv) begin
      cc   <= 34'((64'(cosv[0]) * 64'(cosv[1])) >>> 30);
      sdl2 <= 34'((64'(sinv[2]) * 64'(sinv[2])) >>> 30);
      sdo2 <= 34'((64'(sinv[3]) * 64'(sinv[3])) >>> 30);
      t2     <= 34'((64'(cc) * 64'(sdo2)) >>> 30);
      sdl2_d <= sdl2;
    end
  end

  logic [30:0] a_q;
  logic signed [34:0] asum;
  assign asum = 35'(sdl2_d) + 35'(t2);
  always_ff @(posedge clk) begin
    if (adv) begin
      if (asum < 0) a_q <= '0;
      else if (asum > $signed({4'd0, ONE_Q30})) a_q <= ONE_Q30;
      else a_q <= 31'(asum);
    end
  end

  // ---------------- two square roots, one result bit per stage ----------
  // Digit-by-digit on v = a<<30 (61 bits); remainder and root per lane.
  logic [62:0] rv [2][SQ+1];
  logic [30:0] rr [2][SQ+1];
  always_comb begin
    rv[0][0] = {2'b00, a_q, 30'd0};
    rv[1][0] = {2'b00, ONE_Q30 - a_q, 30'd0};
    rr[0][0] = '0;
    rr[1][0] = '0;
  end
  for (genvar l = 0; l < 2; l++) begin : g_sq
    for (genvar i = 0; i < SQ; i++) begin : g_st
      localparam int B = SQ - 1 - i;
      logic [62:0] trial;
      assign trial = ({32'd0, rr[l][i]} << (B + 1)) | (63'd1 << (2 * B));
      always_ff @(posedge clk) begin
        if (adv) begin
          if (rv[l][i] >= trial) begin
            rv[l][i+1] <= rv[l][i] - trial;
            rr[l][i+1] <= rr[l][i] | (31'd1 << B);
          end else begin
            rv[l][i+1] <= rv[l][i];
            rr[l][i+1] <= rr[l][i];
          end
        end
      end
    end
  end

  // ---------------- atan2 CORDIC ----------------
  logic signed [33:0] ax [N+1];
  logic signed [33:0] ay [N+1];
  logic signed [32:0] az [N+1];
  always_comb begin
    ax[0] = 34'(rr[1][SQ]);
    ay[0] = 34'(rr[0][SQ]);
    az[0] = '0;
  end
  for (genvar i = 0; i < N; i++) begin : g_at
    always_ff @(posedge clk) begin
      if (adv) begin
        if (ay[i] > 0) begin
          ax[i+1] <= ax[i] + (ay[i] >>> (i % 32));
          ay[i+1] <= ay[i] - (ax[i] >>> (i % 32));
          az[i+1] <= az[i] + 33'(atan_turn(i % 32));
        end else begin
          ax[i+1] <= ax[i] - (ay[i] >>> (i % 32));
          ay[i+1] <= ay[i] + (ax[i] >>> (i % 32));
          az[i+1] <= az[i] - 33'(atan_turn(i % 32));
        end
      end
    end
  end

  logic [30:0] zc;
  always_comb begin
    if (az[N] < 0) zc = '0;
    else if (az[N] > $signed({2'd0, ONE_Q30})) zc = ONE_Q30;
    else zc = 31'(az[N]);
  end

  // ---------------- scale by radius ----------------
  // R*wh reaches 59 bits for the largest radius and angle.
  logic [58:0] w;
  logic [58:0] pwh;
  logic [56:0] pwl;
  logic [DIST_W-1:0] dist_q;
  logic [58:0] dsum;
  always_ff @(posedge clk) begin
    if (adv) begin
      w   <= 59'(zc) * 59'(FOUR_PI_Q24);
      pwh <= 59'(radius) * 59'(w[58:28]);
      pwl <= 57'(radius) * 57'(w[27:0]);
      if (dsum[58:28] > 31'(DIST_MAX)) dist_q <= DIST_MAX;
      else dist_q <= dsum[58:28];
    end
  end
  assign dsum = pwh + 59'(pwl >> 28);
  assign distance = dist_q;

endmodule

FILE: src/haversine_distance_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// haversine_distance_top
// Great-circle distance between two points, one item per clock while the output is not stalled.
// ----------------------------------------------------------------------------
// An input item on s_axis carries two points in degrees scaled by 2^20; the
// result on m_axis is the distance in miles, unsigned Q16.16, saturated.
// The sphere radius is written on the cfg channel (cfg_valid/cfg_ready) and
// resets to 3958.8 miles; write it only while the pipeline is empty.
// Throughput is one item per cycle while not stalled. The pipeline depth is
// set by the four sin/cos CORDIC lanes, bit-per-stage square roots, atan2
// CORDIC and the angle, product, clamp, multiply and output registers.
// The whole pipeline advances only when the output register is empty or is
// being taken, so a stalled receiver freezes every stage and nothing is lost
// or repeated; s_axis_tready follows that advance.
// Reset clears all valid bits and restores the default radius.
// ----------------------------------------------------------------------------
module haversine_distance_top #(
  parameter int ANGLE_FRACTION_BITS = hav_pkg::ANGLE_FRACTION_BITS_DEFAULT,
  parameter int CORDIC_STAGES       = hav_pkg::CORDIC_STAGES_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // first_latitude[27:0], first_longitude[56:28], second_latitude[84:57],
  // second_longitude[113:85], zero fill
  input  logic [119:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // distance[30:0], zero fill
  output logic [31:0]  m_axis_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [31:0]  cfg_data          // sphere_radius[28:0]
);
  import hav_pkg::*;

  logic [RADIUS_W-1:0] radius;
  logic adv, core_valid;
  logic [DIST_W-1:0] core_dist;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
    end else if (cfg_valid) begin
      radius <= cfg_data[RADIUS_W-1:0];
    end
  end

  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  hav_core #(
    .ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_core (
    .clk(clk), .rst(rst), .adv(adv),
    .in_valid(s_axis_tvalid),
    .lat1(s_axis_tdata[27:0]),
    .lon1(s_axis_tdata[56:28]),
    .lat2(s_axis_tdata[84:57]),
    .lon2(s_axis_tdata[113:85]),
    .radius(radius),
    .out_valid(core_valid),
    .distance(core_dist)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= core_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      m_axis_tdata <= {1'b0, core_dist};
    end
  end

endmodule

FILE: src/hav_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hav_checker
// Port-level checks for the distance unit, bound to the top level.
// ----------------------------------------------------------------------------
module hav_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);
  import hav_pkg::*;

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");

  // The input side is open exactly when the output can move.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output");

  // Distance never exceeds the saturation value.
  a_sat: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata <= {1'b0, DIST_MAX})
    else $error("distance above maximum");

  // Nothing comes out right after reset.
  a_rst: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("valid after reset");

endmodule

bind haversine_distance_top hav_checker u_hav_checker (
  .clk(clk), .rst(rst), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);
